/* src/tes_pkg.sv */
// Shared types and constants for the timeline event scheduler.
`default_nettype none

package tes_pkg;

	localparam int FRAME_BITS = 24;
	localparam int KEY_BITS   = 16;
	localparam int CMD_BITS   = 4;
	localparam int CFG_BITS   = 3;
	localparam int STAT_BITS  = 2;

	// Command codes of an input transaction.
	localparam logic [CMD_BITS-1:0] OP_TICK       = 4'd0;
	localparam logic [CMD_BITS-1:0] OP_PLAY       = 4'd1;
	localparam logic [CMD_BITS-1:0] OP_STOP       = 4'd2;
	localparam logic [CMD_BITS-1:0] OP_PAUSE      = 4'd3;
	localparam logic [CMD_BITS-1:0] OP_RESUME     = 4'd4;
	localparam logic [CMD_BITS-1:0] OP_SET_ACTIVE = 4'd5;
	localparam logic [CMD_BITS-1:0] OP_SEEK       = 4'd6;
	localparam logic [CMD_BITS-1:0] OP_INSERT     = 4'd7;
	localparam logic [CMD_BITS-1:0] OP_REMOVE     = 4'd8;
	localparam logic [CMD_BITS-1:0] OP_CHANGE     = 4'd9;

	// Configuration register indexes.
	localparam logic [CFG_BITS-1:0] CFG_MIN_FRAME      = 3'd0;
	localparam logic [CFG_BITS-1:0] CFG_MAX_FRAME      = 3'd1;
	localparam logic [CFG_BITS-1:0] CFG_USE_COUNTER    = 3'd2;
	localparam logic [CFG_BITS-1:0] CFG_LOOP_ENABLE    = 3'd3;
	localparam logic [CFG_BITS-1:0] CFG_NOTIFY_DISABLE = 3'd4;

	// Result status codes.
	localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [CMD_BITS-1:0]   command;
		logic [FRAME_BITS-1:0] amount;
		logic [KEY_BITS-1:0]   entry_key;
		logic                  pass_flag;
		logic                  active_flag;
	} item_t;

	typedef struct packed {
		logic                   fired;
		logic [KEY_BITS-1:0]    fired_id;
		logic [FRAME_BITS-1:0]  frame_now;
		logic                   is_playing;
		logic [STAT_BITS-1:0]   status;
		logic                   last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic apply;
		logic idx_clr;
		logic idx_inc;
		logic idx_dec;
		logic idx_to_last;
		logic pos_set;
		logic rd_en;
		logic rd_next;
		logic wr_down;
		logic wr_up;
		logic wr_put;
		logic cnt_inc;
		logic cnt_dec;
		logic st_notfound;
		logic next_win;
		logic emit;
		logic finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_BITS-1:0] op;
		logic scan_go;
		logic full;
		logic at_cnt;
		logic last_idx;
		logic next_ge_cnt;
		logic idx_eq_pos;
		logic win_live;
		logic win2;
		logic t_gt_end;
		logic t_ge_start;
		logic t_le_amt;
		logic id_match;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* src/tes_ctrl.sv */
// Sequencing state machine of the timeline event scheduler.
`default_nettype none

module tes_ctrl import tes_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd,
	output logic          idle
);

	typedef enum logic [15:0] {
		S_IDLE    = 16'b0000_0000_0000_0001,
		S_EXEC    = 16'b0000_0000_0000_0010,
		S_WIN     = 16'b0000_0000_0000_0100,
		S_SCAN_RD = 16'b0000_0000_0000_1000,
		S_SCAN_CK = 16'b0000_0000_0001_0000,
		S_WEND    = 16'b0000_0000_0010_0000,
		S_IDF_RD  = 16'b0000_0000_0100_0000,
		S_IDF_CK  = 16'b0000_0000_1000_0000,
		S_SHDN_RD = 16'b0000_0001_0000_0000,
		S_SHDN_WR = 16'b0000_0010_0000_0000,
		S_LOC_RD  = 16'b0000_0100_0000_0000,
		S_LOC_CK  = 16'b0000_1000_0000_0000,
		S_SHUP_RD = 16'b0001_0000_0000_0000,
		S_SHUP_WR = 16'b0010_0000_0000_0000,
		S_PUT     = 16'b0100_0000_0000_0000,
		S_RESP    = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.apply   = 1'b1;
				cmd.idx_clr = 1'b1;
				case (stat.op)
					OP_TICK:              state_d = stat.scan_go ? S_WIN : S_RESP;
					OP_INSERT:            state_d = stat.full ? S_RESP : S_LOC_RD;
					OP_REMOVE, OP_CHANGE: state_d = S_IDF_RD;
					default:              state_d = S_RESP;
				endcase
			end
			S_WIN: begin
				if (stat.win_live && !stat.at_cnt) begin
					state_d = S_SCAN_RD;
				end else if (stat.win2) begin
					cmd.next_win = 1'b1;
					cmd.idx_clr  = 1'b1;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SCAN_CK;
			end
			S_SCAN_CK: begin
				if (stat.t_gt_end) begin
					state_d = S_WEND;
				end else if (!stat.t_ge_start || !stat.pend_valid || stat.out_free) begin
					// A hit waits here only while an earlier hit cannot leave.
					cmd.emit    = stat.t_ge_start;
					cmd.idx_inc = 1'b1;
					state_d     = stat.last_idx ? S_WEND : S_SCAN_RD;
				end
			end
			S_WEND: begin
				if (stat.win2) begin
					cmd.next_win = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_d      = S_WIN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_IDF_RD: begin
				if (stat.at_cnt) begin
					cmd.st_notfound = 1'b1;
					state_d         = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_IDF_CK;
				end
			end
			S_IDF_CK: begin
				if (stat.id_match) begin
					state_d = S_SHDN_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_IDF_RD;
				end
			end
			S_SHDN_RD: begin
				if (stat.next_ge_cnt) begin
					cmd.cnt_dec = 1'b1;
					if (stat.op == OP_CHANGE) begin
						cmd.idx_clr = 1'b1;
						state_d     = S_LOC_RD;
					end else begin
						state_d = S_RESP;
					end
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SHDN_WR;
				end
			end
			S_SHDN_WR: begin
				cmd.wr_down = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_SHDN_RD;
			end
			S_LOC_RD: begin
				if (stat.at_cnt) begin
					cmd.pos_set = 1'b1;
					state_d     = S_PUT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_LOC_CK;
				end
			end
			S_LOC_CK: begin
				if (stat.t_le_amt) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_LOC_RD;
				end else begin
					cmd.pos_set     = 1'b1;
					cmd.idx_to_last = 1'b1;
					state_d         = S_SHUP_RD;
				end
			end
			S_SHUP_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SHUP_WR;
			end
			S_SHUP_WR: begin
				cmd.wr_up = 1'b1;
				if (stat.idx_eq_pos) begin
					state_d = S_PUT;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d     = S_SHUP_RD;
				end
			end
			S_PUT: begin
				cmd.wr_put  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/tes_datapath.sv */
// Frame registers, notify table memory and result register of the scheduler.
`default_nettype none

module tes_datapath import tes_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_BITS-1:0]   cfg_index,
	input  wire logic [FRAME_BITS-1:0] cfg_data,
	input  wire item_t                 item,
	input  wire ctl_cmd_t              cmd,
	input  wire logic                  result_stall,
	output dp_stat_t                   stat,
	output logic                       result_valid,
	output result_t                    result
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [FRAME_BITS-1:0] min_frame_q, max_frame_q, cur_q, prev_q;
	logic                  use_counter_q, loop_enable_q, notify_disable_q;
	logic                  playing_q, active_q;
	logic [CW-1:0]         count_q, idx_q, pos_q;
	item_t                 item_q;
	logic [FRAME_BITS-1:0] ws_q, we_q, we2_q;
	logic                  win2_q;
	logic [STAT_BITS-1:0]  status_q;
	logic                  pend_valid_q;
	logic [KEY_BITS-1:0]   pend_id_q;
	logic [FRAME_BITS-1:0] rd_time_q;
	logic [KEY_BITS-1:0]   rd_id_q;
	logic                  result_valid_q;
	result_t               result_q;

	logic [FRAME_BITS-1:0] mem_time [TABLE_DEPTH];
	logic [KEY_BITS-1:0]   mem_id   [TABLE_DEPTH];

	logic [FRAME_BITS:0]   sum;
	logic [FRAME_BITS-1:0] sat, adv, cur1, seek_frame, cfg_min, cfg_max, clamped;
	logic                  counting, tick_ok, full, out_free, push;
	logic [CW-1:0]         idx_p1;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic                  mem_we;
	logic [FRAME_BITS-1:0] wr_time;
	logic [KEY_BITS-1:0]   wr_id;
	result_t               push_val;

	// Tick arithmetic: saturating advance, floored at the start frame.
	always_comb begin
		sum        = {1'b0, cur_q} + {1'b0, item_q.amount};
		sat        = sum[FRAME_BITS] ? '1 : sum[FRAME_BITS-1:0];
		adv        = (sat < min_frame_q) ? min_frame_q : sat;
		counting   = playing_q && use_counter_q;
		cur1       = counting ? adv : cur_q;
		tick_ok    = (max_frame_q >= min_frame_q) && active_q;
		seek_frame = (item_q.amount < min_frame_q) ? min_frame_q : item_q.amount;
	end

	// A write to either bound pulls the current frame into the new range.
	always_comb begin
		cfg_min = (cfg_index == CFG_MIN_FRAME) ? cfg_data : min_frame_q;
		cfg_max = (cfg_index == CFG_MAX_FRAME) ? cfg_data : max_frame_q;
		if (cur_q < cfg_min) begin
			clamped = cfg_min;
		end else if (cur_q > cfg_max) begin
			clamped = cfg_max;
		end else begin
			clamped = cur_q;
		end
	end

	// Configuration, frame state and scan windows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_frame_q      <= '0;
			max_frame_q      <= '0;
			use_counter_q    <= 1'b1;
			loop_enable_q    <= 1'b0;
			notify_disable_q <= 1'b0;
			cur_q            <= '0;
			prev_q           <= '0;
			playing_q        <= 1'b0;
			active_q         <= 1'b1;
			ws_q             <= '0;
			we_q             <= '0;
			we2_q            <= '0;
			win2_q           <= 1'b0;
			status_q         <= ST_OK;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_FRAME: begin
					min_frame_q <= cfg_data;
					cur_q       <= clamped;
				end
				CFG_MAX_FRAME: begin
					max_frame_q <= cfg_data;
					cur_q       <= clamped;
				end
				CFG_USE_COUNTER:    use_counter_q    <= cfg_data[0];
				CFG_LOOP_ENABLE:    loop_enable_q    <= cfg_data[0];
				CFG_NOTIFY_DISABLE: notify_disable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end else if (cmd.apply) begin
			status_q <= (item_q.command == OP_INSERT && full) ? ST_FULL : ST_OK;
			case (item_q.command)
				OP_TICK: begin
					if (tick_ok) begin
						ws_q  <= prev_q;
						we2_q <= cur1;
						if (prev_q > cur1) begin
							we_q   <= max_frame_q;
							win2_q <= 1'b1;
						end else begin
							we_q   <= cur1;
							win2_q <= 1'b0;
						end
						prev_q <= cur1;
						if (counting && cur1 >= max_frame_q) begin
							if (loop_enable_q) begin
								cur_q <= cur1 - (max_frame_q - min_frame_q);
							end else begin
								cur_q     <= max_frame_q;
								prev_q    <= max_frame_q;
								playing_q <= 1'b0;
							end
						end else begin
							cur_q <= cur1;
						end
					end
				end
				OP_PLAY, OP_STOP: begin
					playing_q <= (item_q.command == OP_PLAY);
					cur_q     <= min_frame_q;
					prev_q    <= min_frame_q;
				end
				OP_PAUSE:      playing_q <= 1'b0;
				OP_RESUME:     playing_q <= 1'b1;
				OP_SET_ACTIVE: active_q  <= item_q.active_flag;
				OP_SEEK: begin
					cur_q <= seek_frame;
					if (item_q.pass_flag || !active_q) begin
						prev_q <= seek_frame;
					end
				end
				default: begin
				end
			endcase
		end else begin
			if (cmd.next_win) begin
				ws_q   <= min_frame_q;
				we_q   <= we2_q;
				win2_q <= 1'b0;
			end
			if (cmd.st_notfound) begin
				status_q <= ST_NOT_FOUND;
			end
		end
	end

	// Input transaction capture.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
	end

	// Table index, insert position and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end else if (cmd.idx_to_last) begin
				idx_q <= count_q - CW'(1);
			end
			if (cmd.pos_set) begin
				pos_q <= idx_q;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign idx_p1 = idx_q + CW'(1);
	assign full   = (count_q == CW'(TABLE_DEPTH));

	// Table memory: one write and one registered read per cycle.
	always_comb begin
		rd_addr = cmd.rd_next ? idx_p1[AW-1:0] : idx_q[AW-1:0];
		mem_we  = cmd.wr_down || cmd.wr_up || cmd.wr_put;
		if (cmd.wr_put) begin
			wr_addr = pos_q[AW-1:0];
			wr_time = item_q.amount;
			wr_id   = item_q.entry_key;
		end else if (cmd.wr_up) begin
			wr_addr = idx_p1[AW-1:0];
			wr_time = rd_time_q;
			wr_id   = rd_id_q;
		end else begin
			wr_addr = idx_q[AW-1:0];
			wr_time = rd_time_q;
			wr_id   = rd_id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_time[wr_addr] <= wr_time;
			mem_id[wr_addr]   <= wr_id;
		end
		if (cmd.rd_en) begin
			rd_time_q <= mem_time[rd_addr];
			rd_id_q   <= mem_id[rd_addr];
		end
	end

	// One hit is held back so that the final transaction can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_id_q <= rd_id_q;
		end
	end

	// Output register.
	assign out_free = !result_valid_q || !result_stall;
	assign push     = cmd.finish || (cmd.emit && pend_valid_q);

	always_comb begin
		push_val.fired      = pend_valid_q;
		push_val.fired_id   = pend_valid_q ? pend_id_q : '0;
		push_val.frame_now  = cur_q;
		push_val.is_playing = playing_q;
		push_val.status     = status_q;
		push_val.last       = cmd.finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			result_q <= push_val;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Status toward the controller.
	always_comb begin
		stat.op          = item_q.command;
		stat.scan_go     = tick_ok && (cur1 != prev_q);
		stat.full        = full;
		stat.at_cnt      = (idx_q == count_q);
		stat.last_idx    = (idx_p1 == count_q);
		stat.next_ge_cnt = (idx_p1 >= count_q);
		stat.idx_eq_pos  = (idx_q == pos_q);
		stat.win_live    = (ws_q < we_q) && !notify_disable_q;
		stat.win2        = win2_q;
		stat.t_gt_end    = (rd_time_q > we_q);
		stat.t_ge_start  = (rd_time_q >= ws_q);
		stat.t_le_amt    = (rd_time_q <= item_q.amount);
		stat.id_match    = (rd_id_q == item_q.entry_key);
		stat.pend_valid  = pend_valid_q;
		stat.out_free    = out_free;
	end

endmodule

`default_nettype wire

/* src/timeline_event_scheduler.sv */
// Top level of the timeline event scheduler: controller plus datapath.
//
//   channel   | handshake                   | payload
//   item      | item_valid / item_stall     | item (item_t)
//   result    | result_valid / result_stall | result (result_t)
//   config    | cfg_we                      | cfg_index, cfg_data
//
// One command at a time. A simple command runs through the latch, apply and
// response states, and the next command is taken only once the block is idle
// again. Table work visits one entry at a time through the single memory read
// port, with a read state and a check or write state for each entry visited.
// Reset needs no clearing pass.
// A stalled result holds the sequencer only when a further result is due.
`default_nettype none

module timeline_event_scheduler import tes_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_BITS-1:0]   cfg_index,
	input  wire logic [FRAME_BITS-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     idle;

	tes_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.stat       (stat),
		.cmd        (cmd),
		.idle       (idle)
	);

	tes_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

	assign item_stall = !idle;

`ifndef SYNTH
	// A taken transaction keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block not busy after accepting a transaction");

	// A result without a hit is always the only result of its command.
	a_nohit_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.fired |-> result.last)
		else $error("result without a hit is not marked last");

	// Error status only comes with table commands, never with a hit.
	a_status_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_OK) |-> !result.fired && result.last)
		else $error("error status on a hit result");
`endif

endmodule

`default_nettype wire
